>>> hw/rtl/pssc_pkg.sv
`default_nettype none

package pssc_pkg;

  // Port widths fixed by the interface
  localparam int COORD_W   = 24;
  localparam int BOX_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int COUNT_W   = 3;
  localparam int PIX_W     = 16;
  // Pixel coordinate plus size never leaves this width
  localparam int PIXE_W    = PIX_W + 2;
  localparam int BOX_REGS  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ZERO  = 3'd1;

  typedef logic signed [PIXE_W-1:0] pix_t;

  typedef struct packed {
    logic en;
    logic land;
    logic src;
    logic cov_x;
    logic cov_y;
    logic left_x;
    logic right_x;
    logic up_y;
    logic down_y;
  } slot_flags_t;

  function automatic pix_t box_x(input logic [BOX_W-1:0] b);
    box_x = {{(PIXE_W-PIX_W){b[63]}}, b[63:48]};
  endfunction

  function automatic pix_t box_y(input logic [BOX_W-1:0] b);
    box_y = {{(PIXE_W-PIX_W){b[47]}}, b[47:32]};
  endfunction

  function automatic pix_t box_x_end(input logic [BOX_W-1:0] b);
    box_x_end = box_x(b) + signed'({{(PIXE_W-PIX_W){1'b0}}, b[31:16]});
  endfunction

  function automatic pix_t box_y_end(input logic [BOX_W-1:0] b);
    box_y_end = box_y(b) + signed'({{(PIXE_W-PIX_W){1'b0}}, b[15:0]});
  endfunction

  function automatic logic box_enabled(input logic [BOX_W-1:0] b);
    box_enabled = (|b[31:16]) && (|b[15:0]);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pointer_screen_seam_crossing.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        sink       in_valid/in_ready    pointer_x, pointer_y, delta_x, delta_y
// out       source     out_valid/out_ready  crossed, new_x, new_y
// cfg       sink       cfg_write            cfg_index, cfg_data
//
// One request per cycle while out is not stalled; a result passes four register stages:
// sum, per-screen geometry, source and candidate selection, nearest-screen pick
// with output register.
// Reset clears the stage valid bits, the screen count and all screen boxes.
// A stall on out holds every full stage while empty ones keep filling; in_ready
// drops only when all stages are full.
module pointer_screen_seam_crossing #(
  parameter int MAX_SCREENS = 4,
  parameter int FRAC_BITS   = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [pssc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [pssc_pkg::BOX_W-1:0]            cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [pssc_pkg::COORD_W-1:0]   pointer_x,
  input  wire logic signed [pssc_pkg::COORD_W-1:0]   pointer_y,
  input  wire logic signed [pssc_pkg::COORD_W-1:0]   delta_x,
  input  wire logic signed [pssc_pkg::COORD_W-1:0]   delta_y,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic                                       crossed,
  output logic signed [pssc_pkg::COORD_W-1:0]        new_x,
  output logic signed [pssc_pkg::COORD_W-1:0]        new_y
);
  import pssc_pkg::*;

  localparam int NSLOT = (MAX_SCREENS < BOX_REGS) ? MAX_SCREENS : BOX_REGS;
  localparam int CW    = (FRAC_BITS + 19 > 26) ? FRAC_BITS + 19 : 26;

  // Configuration
  logic [COUNT_W-1:0] screen_count;
  logic [BOX_W-1:0]   box [NSLOT];

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_count <= '0;
      for (int i = 0; i < NSLOT; i++) begin
        box[i] <= '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == REG_SCREEN_COUNT) begin
        screen_count <= cfg_data[COUNT_W-1:0];
      end
      for (int i = 0; i < NSLOT; i++) begin
        if (cfg_index == REG_SCREEN_ZERO + CFG_IDX_W'(i)) begin
          box[i] <= cfg_data;
        end
      end
    end
  end

  // Stage enables
  logic s1_valid, s2_valid, s3_valid;
  logic en1, en2, en3, en4;

  assign en4      = !out_valid || out_ready;
  assign en3      = !s3_valid || en4;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  // Stage 1: moved point
  logic signed [CW-1:0] px_in, py_in, dx_in, dy_in;
  logic signed [CW-1:0] s1_px, s1_py, s1_nx, s1_ny;

  assign px_in = {{(CW-COORD_W){pointer_x[COORD_W-1]}}, pointer_x};
  assign py_in = {{(CW-COORD_W){pointer_y[COORD_W-1]}}, pointer_y};
  assign dx_in = {{(CW-COORD_W){delta_x[COORD_W-1]}}, delta_x};
  assign dy_in = {{(CW-COORD_W){delta_y[COORD_W-1]}}, delta_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_px <= px_in;
      s1_py <= py_in;
      s1_nx <= px_in + dx_in;
      s1_ny <= py_in + dy_in;
    end
  end

  // Stage 2: per-screen geometry
  slot_flags_t                 flags_c [NSLOT];
  logic [CW-1:0]               gx_c [NSLOT];
  logic [CW-1:0]               gy_c [NSLOT];
  logic signed [COORD_W-1:0]   cx_c [NSLOT];
  logic signed [COORD_W-1:0]   cy_c [NSLOT];

  for (genvar i = 0; i < NSLOT; i++) begin : g_slot
    pssc_slot #(
      .FRAC_BITS(FRAC_BITS),
      .CW(CW)
    ) u_slot (
      .box(box[i]),
      .active(screen_count > COUNT_W'(i)),
      .px(s1_px),
      .py(s1_py),
      .nx(s1_nx),
      .ny(s1_ny),
      .flags(flags_c[i]),
      .gap_x(gx_c[i]),
      .gap_y(gy_c[i]),
      .clamp_x(cx_c[i]),
      .clamp_y(cy_c[i])
    );
  end

  slot_flags_t                 s2_flags [NSLOT];
  logic [CW-1:0]               s2_gx [NSLOT];
  logic [CW-1:0]               s2_gy [NSLOT];
  logic signed [COORD_W-1:0]   s2_cx [NSLOT];
  logic signed [COORD_W-1:0]   s2_cy [NSLOT];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid) begin
      for (int i = 0; i < NSLOT; i++) begin
        s2_flags[i] <= flags_c[i];
        s2_gx[i]    <= gx_c[i];
        s2_gy[i]    <= gy_c[i];
        s2_cx[i]    <= cx_c[i];
        s2_cy[i]    <= cy_c[i];
      end
    end
  end

  // Stage 3: source screen and candidates beyond the exited edge
  logic [NSLOT-1:0] from_oh, cand_x, cand_y;
  logic [NSLOT-1:0] s3_cand_x, s3_cand_y;
  logic [CW-1:0]    s3_gx [NSLOT];
  logic [CW-1:0]    s3_gy [NSLOT];
  logic signed [COORD_W-1:0] s3_cx [NSLOT];
  logic signed [COORD_W-1:0] s3_cy [NSLOT];

  always_comb begin
    logic found, landed, go, side_x, side_y;
    found   = 1'b0;
    landed  = 1'b0;
    from_oh = '0;
    for (int j = 0; j < NSLOT; j++) begin
      landed = landed | s2_flags[j].land;
      if (s2_flags[j].src && !found) begin
        found      = 1'b1;
        from_oh[j] = 1'b1;
      end
    end
    go = found && !landed;
    for (int i = 0; i < NSLOT; i++) begin
      side_x = 1'b0;
      side_y = 1'b0;
      for (int j = 0; j < NSLOT; j++) begin
        if (from_oh[j]) begin
          if (s2_flags[j].right_x) begin
            side_x = box_x(box[i]) >= box_x_end(box[j]);
          end else begin
            side_x = s2_flags[j].left_x && (box_x_end(box[i]) <= box_x(box[j]));
          end
          if (s2_flags[j].down_y) begin
            side_y = box_y(box[i]) >= box_y_end(box[j]);
          end else begin
            side_y = s2_flags[j].up_y && (box_y_end(box[i]) <= box_y(box[j]));
          end
        end
      end
      cand_x[i] = go && !from_oh[i] && s2_flags[i].en && s2_flags[i].cov_x && side_x;
      cand_y[i] = go && !from_oh[i] && s2_flags[i].en && s2_flags[i].cov_y && side_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && s2_valid) begin
      s3_cand_x <= cand_x;
      s3_cand_y <= cand_y;
      for (int i = 0; i < NSLOT; i++) begin
        s3_gx[i] <= s2_gx[i];
        s3_gy[i] <= s2_gy[i];
        s3_cx[i] <= s2_cx[i];
        s3_cy[i] <= s2_cy[i];
      end
    end
  end

  // Stage 4: nearest candidate, lower index on a tie; vertical search only as fallback
  logic                       sel_hit;
  logic signed [COORD_W-1:0]  sel_x, sel_y;

  always_comb begin
    logic          hit_x, hit_y;
    logic [CW-1:0] best_x, best_y;
    logic [NSLOT-1:0] pick_x, pick_y, pick;
    hit_x  = 1'b0;
    hit_y  = 1'b0;
    best_x = '0;
    best_y = '0;
    pick_x = '0;
    pick_y = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (s3_cand_x[i] && (!hit_x || (s3_gy[i] < best_x))) begin
        hit_x     = 1'b1;
        best_x    = s3_gy[i];
        pick_x    = '0;
        pick_x[i] = 1'b1;
      end
      if (s3_cand_y[i] && (!hit_y || (s3_gx[i] < best_y))) begin
        hit_y     = 1'b1;
        best_y    = s3_gx[i];
        pick_y    = '0;
        pick_y[i] = 1'b1;
      end
    end
    pick    = hit_x ? pick_x : pick_y;
    sel_hit = hit_x || hit_y;
    sel_x   = '0;
    sel_y   = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (pick[i]) begin
        sel_x = s3_cx[i];
        sel_y = s3_cy[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en4) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && s3_valid) begin
      crossed <= sel_hit;
      new_x   <= sel_x;
      new_y   <= sel_y;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pssc_slot.sv
`default_nettype none

// Geometry of one screen against the start and the moved point.
module pssc_slot #(
  parameter int FRAC_BITS = 8,
  parameter int CW        = 27
) (
  input  wire logic [pssc_pkg::BOX_W-1:0]          box,
  input  wire logic                                active,
  input  wire logic signed [CW-1:0]                px,
  input  wire logic signed [CW-1:0]                py,
  input  wire logic signed [CW-1:0]                nx,
  input  wire logic signed [CW-1:0]                ny,
  output pssc_pkg::slot_flags_t                    flags,
  output logic [CW-1:0]                            gap_x,
  output logic [CW-1:0]                            gap_y,
  output logic signed [pssc_pkg::COORD_W-1:0]      clamp_x,
  output logic signed [pssc_pkg::COORD_W-1:0]      clamp_y
);
  import pssc_pkg::*;

  localparam logic signed [CW-1:0] SAT_MAX = CW'(2 ** (COORD_W - 1) - 1);
  localparam logic signed [CW-1:0] SAT_MIN = ~SAT_MAX;

  pix_t bx, by, bx_end, by_end, bx_last, by_last;
  logic signed [CW-1:0] lo_x, end_x, last_x, lo_y, end_y, last_y;
  logic signed [CW-1:0] diff_x, diff_y, cx, cy;
  logic en, below_x, above_x, below_y, above_y;

  assign bx      = box_x(box);
  assign by      = box_y(box);
  assign bx_end  = box_x_end(box);
  assign by_end  = box_y_end(box);
  assign bx_last = bx_end - pix_t'(1);
  assign by_last = by_end - pix_t'(1);

  assign lo_x   = {{(CW-PIXE_W){bx[PIXE_W-1]}}, bx} <<< FRAC_BITS;
  assign end_x  = {{(CW-PIXE_W){bx_end[PIXE_W-1]}}, bx_end} <<< FRAC_BITS;
  assign last_x = {{(CW-PIXE_W){bx_last[PIXE_W-1]}}, bx_last} <<< FRAC_BITS;
  assign lo_y   = {{(CW-PIXE_W){by[PIXE_W-1]}}, by} <<< FRAC_BITS;
  assign end_y  = {{(CW-PIXE_W){by_end[PIXE_W-1]}}, by_end} <<< FRAC_BITS;
  assign last_y = {{(CW-PIXE_W){by_last[PIXE_W-1]}}, by_last} <<< FRAC_BITS;

  assign en = active && box_enabled(box);

  assign below_x = nx < lo_x;
  assign above_x = nx > last_x;
  assign below_y = ny < lo_y;
  assign above_y = ny > last_y;

  always_comb begin
    flags.en      = en;
    flags.cov_x   = !below_x && (nx < end_x);
    flags.cov_y   = !below_y && (ny < end_y);
    flags.left_x  = below_x;
    flags.right_x = nx >= end_x;
    flags.up_y    = below_y;
    flags.down_y  = ny >= end_y;
    flags.land    = en && flags.cov_x && flags.cov_y;
    flags.src     = en && (px >= lo_x) && (px < end_x) && (py >= lo_y) && (py < end_y);
  end

  // Distance to the nearest covered pixel row or column, zero when inside
  always_comb begin
    if (below_x) begin
      diff_x = lo_x - nx;
    end else if (above_x) begin
      diff_x = nx - last_x;
    end else begin
      diff_x = '0;
    end
    if (below_y) begin
      diff_y = lo_y - ny;
    end else if (above_y) begin
      diff_y = ny - last_y;
    end else begin
      diff_y = '0;
    end
  end

  assign gap_x = diff_x;
  assign gap_y = diff_y;

  always_comb begin
    cx = below_x ? lo_x : (above_x ? last_x : nx);
    cy = below_y ? lo_y : (above_y ? last_y : ny);
    if (cx < SAT_MIN) begin
      cx = SAT_MIN;
    end else if (cx > SAT_MAX) begin
      cx = SAT_MAX;
    end
    if (cy < SAT_MIN) begin
      cy = SAT_MIN;
    end else if (cy > SAT_MAX) begin
      cy = SAT_MAX;
    end
  end

  assign clamp_x = cx[COORD_W-1:0];
  assign clamp_y = cy[COORD_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/pssc_check.sv
`default_nettype none

module pssc_check (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic                                 crossed,
  input wire logic signed [pssc_pkg::COORD_W-1:0]  new_x,
  input wire logic signed [pssc_pkg::COORD_W-1:0]  new_y
);

  // A result that is not redirected carries a zero point
  a_zero_when_not_crossed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !crossed |-> (new_x == '0) && (new_y == '0))
    else $error("non-crossing result carries a nonzero point");

  // Pipeline comes out of reset empty
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(crossed) && $stable(new_x) && $stable(new_y))
    else $error("result changed while stalled");

endmodule

bind pointer_screen_seam_crossing pssc_check u_pssc_check (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .crossed(crossed),
  .new_x(new_x),
  .new_y(new_y)
);

`default_nettype wire

>>> bench/seam_crossing_checker.sv
`timescale 1ns / 1ps

module seam_crossing_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pssc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pssc_pkg::BOX_W-1:0]          cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [pssc_pkg::COORD_W-1:0] pointer_x,
  input  logic signed [pssc_pkg::COORD_W-1:0] pointer_y,
  input  logic signed [pssc_pkg::COORD_W-1:0] delta_x,
  input  logic signed [pssc_pkg::COORD_W-1:0] delta_y,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                crossed,
  input  logic signed [pssc_pkg::COORD_W-1:0] new_x,
  input  logic signed [pssc_pkg::COORD_W-1:0] new_y,
  output int                                  fail_count,
  output int                                  pending_count
);
  import pssc_pkg::*;

  localparam int     FRAC      = 8;
  localparam longint PIXEL     = longint'(1) << FRAC;
  localparam longint COORD_MAX = 8388607;
  localparam longint COORD_MIN = -8388608;

  typedef struct packed {
    logic                      crossed;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } landing_t;

  logic [COUNT_W-1:0] screens_used;
  logic [BOX_W-1:0]   screen_box [BOX_REGS];
  landing_t           expected_landings [$];

  function automatic longint left_of(input int i);
    return longint'($signed(screen_box[i][63:48]));
  endfunction

  function automatic longint top_of(input int i);
    return longint'($signed(screen_box[i][47:32]));
  endfunction

  function automatic longint width_of(input int i);
    return longint'(screen_box[i][31:16]);
  endfunction

  function automatic longint height_of(input int i);
    return longint'(screen_box[i][15:0]);
  endfunction

  function automatic bit screen_on(input int i);
    return width_of(i) > 0 && height_of(i) > 0;
  endfunction

  function automatic bit spans_x(input int i, input longint px);
    return px >= left_of(i) * PIXEL && px < (left_of(i) + width_of(i)) * PIXEL;
  endfunction

  function automatic bit spans_y(input int i, input longint py);
    return py >= top_of(i) * PIXEL && py < (top_of(i) + height_of(i)) * PIXEL;
  endfunction

  function automatic bit holds_point(input int i, input longint px, input longint py);
    return screen_on(i) && spans_x(i, px) && spans_y(i, py);
  endfunction

  // distance from v to the pixel range [lo, lo + len - 1]
  function automatic longint gap_to_span(input longint v, input longint lo, input longint len);
    if (v < lo * PIXEL) return lo * PIXEL - v;
    if (v > (lo + len - 1) * PIXEL) return v - (lo + len - 1) * PIXEL;
    return 0;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic landing_t predict_landing(
    input logic signed [COORD_W-1:0] px,
    input logic signed [COORD_W-1:0] py,
    input logic signed [COORD_W-1:0] dx,
    input logic signed [COORD_W-1:0] dy
  );
    landing_t res;
    int       n;
    int       from;
    int       to;
    longint   nx;
    longint   ny;
    longint   best;
    longint   g;
    longint   mx;
    longint   my;
    bit       far_side;
    res  = '0;
    from = -1;
    to   = -1;
    best = 0;
    n = (screens_used > BOX_REGS) ? BOX_REGS : int'(screens_used);
    if (n == 0) return res;
    nx = longint'(px) + longint'(dx);
    ny = longint'(py) + longint'(dy);
    for (int i = 0; i < n; i++) begin
      if (holds_point(i, nx, ny)) return res;
    end
    for (int i = 0; i < n; i++) begin
      if (from < 0 && holds_point(i, px, py)) from = i;
    end
    if (from < 0) return res;

    // first look past the vertical edge that was left
    if (!spans_x(from, nx)) begin
      far_side = nx >= (left_of(from) + width_of(from)) * PIXEL;
      for (int i = 0; i < n; i++) begin
        if (i != from && screen_on(i) && spans_x(i, nx) &&
            (far_side ? left_of(i) >= left_of(from) + width_of(from)
                      : left_of(i) + width_of(i) <= left_of(from))) begin
          g = gap_to_span(ny, top_of(i), height_of(i));
          if (to < 0 || g < best) begin
            to   = i;
            best = g;
          end
        end
      end
    end
    if (to < 0 && !spans_y(from, ny)) begin
      far_side = ny >= (top_of(from) + height_of(from)) * PIXEL;
      for (int i = 0; i < n; i++) begin
        if (i != from && screen_on(i) && spans_y(i, ny) &&
            (far_side ? top_of(i) >= top_of(from) + height_of(from)
                      : top_of(i) + height_of(i) <= top_of(from))) begin
          g = gap_to_span(nx, left_of(i), width_of(i));
          if (to < 0 || g < best) begin
            to   = i;
            best = g;
          end
        end
      end
    end
    if (to < 0) return res;

    mx = clip(nx, left_of(to) * PIXEL, (left_of(to) + width_of(to) - 1) * PIXEL);
    my = clip(ny, top_of(to) * PIXEL, (top_of(to) + height_of(to) - 1) * PIXEL);
    mx = clip(mx, COORD_MIN, COORD_MAX);
    my = clip(my, COORD_MIN, COORD_MAX);
    res.crossed = 1'b1;
    res.x       = mx[COORD_W-1:0];
    res.y       = my[COORD_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    landing_t want;
    if (rst) begin
      screens_used = '0;
      foreach (screen_box[i]) screen_box[i] = '0;
      expected_landings.delete();
      fail_count = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_SCREEN_COUNT) begin
          screens_used = cfg_data[COUNT_W-1:0];
        end else if (cfg_index >= REG_SCREEN_ZERO &&
                     cfg_index < REG_SCREEN_ZERO + BOX_REGS) begin
          screen_box[2'(cfg_index - REG_SCREEN_ZERO)] = cfg_data;
        end
      end
      if (in_valid && in_ready)
        expected_landings.push_back(predict_landing(pointer_x, pointer_y, delta_x, delta_y));
      if (out_valid && out_ready) begin
        if (expected_landings.size() == 0) begin
          $error("unexpected result: crossed %0b new_x %0d new_y %0d", crossed, new_x, new_y);
          fail_count++;
        end else begin
          want = expected_landings.pop_front();
          if (crossed !== want.crossed) begin
            $error("crossed: expected %0b, got %0b", want.crossed, crossed);
            fail_count++;
          end
          if (new_x !== want.x) begin
            $error("new_x: expected %0d, got %0d", want.x, new_x);
            fail_count++;
          end
          if (new_y !== want.y) begin
            $error("new_y: expected %0d, got %0d", want.y, new_y);
            fail_count++;
          end
        end
      end
    end
    pending_count = expected_landings.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import pssc_pkg::*;

  localparam longint PIXEL           = 256;
  localparam longint COORD_MAX       = 8388607;
  localparam longint COORD_MIN       = -8388608;
  localparam int     HOLD_OFF_CYCLES = 60;
  localparam int     SETTLE_CYCLES   = 8;
  localparam int     STALL_LIMIT     = 4000;
  localparam int     PHASES          = 10;
  localparam int     PHASE_REQUESTS  = 56;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_SCREEN_ZERO + 3'(BOX_REGS);

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [BOX_W-1:0]          cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [COORD_W-1:0] pointer_x;
  logic signed [COORD_W-1:0] pointer_y;
  logic signed [COORD_W-1:0] delta_x;
  logic signed [COORD_W-1:0] delta_y;
  logic                      out_valid;
  logic                      out_ready;
  logic                      crossed;
  logic signed [COORD_W-1:0] new_x;
  logic signed [COORD_W-1:0] new_y;
  int                        fail_count;
  int                        pending_count;

  logic [BOX_W-1:0] screen_plan [BOX_REGS];
  bit               send_jitter;
  bit               sink_jitter;
  bit               hold_off_request;
  int               quiet_cycles;

  pointer_screen_seam_crossing dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pointer_x (pointer_x),
    .pointer_y (pointer_y),
    .delta_x   (delta_x),
    .delta_y   (delta_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .crossed   (crossed),
    .new_x     (new_x),
    .new_y     (new_y)
  );

  seam_crossing_checker crossing_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pointer_x     (pointer_x),
    .pointer_y     (pointer_y),
    .delta_x       (delta_x),
    .delta_y       (delta_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .crossed       (crossed),
    .new_x         (new_x),
    .new_y         (new_y),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [COORD_W-1:0] to_coord(input longint v);
    longint c;
    c = v;
    if (c > COORD_MAX) c = COORD_MAX;
    if (c < COORD_MIN) c = COORD_MIN;
    return c[COORD_W-1:0];
  endfunction

  function automatic longint noise();
    logic [COORD_W-1:0] v;
    v = COORD_W'($urandom);
    return longint'($signed(v));
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [BOX_W-1:0] pack_box(input int x, input int y, input int w, input int h);
    return {x[15:0], y[15:0], w[15:0], h[15:0]};
  endfunction

  function automatic longint plan_left(input int i);
    return longint'($signed(screen_plan[i][63:48]));
  endfunction

  function automatic longint plan_top(input int i);
    return longint'($signed(screen_plan[i][47:32]));
  endfunction

  function automatic longint plan_width(input int i);
    return longint'(screen_plan[i][31:16]);
  endfunction

  function automatic longint plan_height(input int i);
    return longint'(screen_plan[i][15:0]);
  endfunction

  function automatic longint pick(input longint lo, input longint span);
    if (span <= 0) return lo;
    return lo + longint'($urandom_range(0, 32'(span - 1)));
  endfunction

  // called at a falling edge; raises the write enable with the index and data and leaves it low on return
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BOX_W-1:0] value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_screen(input int slot, input logic [BOX_W-1:0] value);
    screen_plan[slot] = value;
    write_reg(REG_SCREEN_ZERO + slot[CFG_IDX_W-1:0], value);
  endtask

  task automatic set_count(input int n);
    write_reg(REG_SCREEN_COUNT, BOX_W'(n));
  endtask

  // hold off new requests until every result is back
  task automatic settle();
    in_valid = 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_request(input longint px, input longint py, input longint dx,
                              input longint dy);
    if (send_jitter && $urandom_range(0, 2) == 0) begin
      in_valid = 1'b0;
      repeat (idle_length()) @(negedge clk);
    end
    pointer_x = to_coord(px);
    pointer_y = to_coord(py);
    delta_x   = to_coord(dx);
    delta_y   = to_coord(dy);
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // start on a planned screen and aim around another one, with some noise
  task automatic push_random_request();
    int     r;
    int     s;
    int     t;
    longint sx;
    longint sy;
    longint tx;
    longint ty;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, BOX_REGS - 1);
    t = $urandom_range(0, BOX_REGS - 1);
    sx = pick(plan_left(s) * PIXEL, plan_width(s) * PIXEL);
    sy = pick(plan_top(s) * PIXEL, plan_height(s) * PIXEL);
    if (r < 15) begin
      push_request(noise(), noise(), noise(), noise());
    end else if (r < 30) begin
      push_request(sx, sy, pick(-16 * PIXEL, 32 * PIXEL), pick(-16 * PIXEL, 32 * PIXEL));
    end else begin
      tx = pick((plan_left(t) - plan_width(t) / 2) * PIXEL, (2 * plan_width(t) + 1) * PIXEL);
      ty = pick((plan_top(t) - plan_height(t) / 2) * PIXEL, (2 * plan_height(t) + 1) * PIXEL);
      push_request(sx, sy, tx - sx, ty - sy);
    end
  endtask

  task automatic plan_layout(input int style);
    int               cursor;
    int               x;
    int               y;
    int               w;
    int               h;
    int               r;
    logic [BOX_W-1:0] box;
    cursor = -int'($urandom_range(0, 400));
    for (int i = 0; i < BOX_REGS; i++) begin
      w = $urandom_range(40, 200);
      h = $urandom_range(40, 200);
      x = 0;
      y = 0;
      r = $urandom_range(0, 2);
      case (style)
        0: begin
          x = cursor;
          y = int'($urandom_range(0, 200)) - 100;
          cursor += w + int'($urandom_range(0, 30));
        end
        1: begin
          y = cursor;
          x = int'($urandom_range(0, 200)) - 100;
          cursor += h + int'($urandom_range(0, 30));
        end
        2: begin
          x = (i % 2) * (200 + int'($urandom_range(0, 30)));
          y = (i / 2) * (200 + int'($urandom_range(0, 30)));
        end
        3: begin
          x = int'($urandom_range(0, 600)) - 300;
          y = int'($urandom_range(0, 600)) - 300;
          w = $urandom_range(1, 250);
          h = $urandom_range(1, 250);
        end
        default: begin
          if (r == 1) begin
            x = 32767 - int'($urandom_range(0, 800));
            y = int'($urandom_range(0, 400)) - 200;
            w = $urandom_range(1, 65535);
            h = $urandom_range(1, 400);
          end else begin
            x = -32768 + int'($urandom_range(0, 800));
            y = 32767 - int'($urandom_range(0, 800));
            w = $urandom_range(1, 2000);
            h = $urandom_range(1, 65535);
          end
        end
      endcase
      if (style != 4 && $urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1) == 0) w = 0;
        else h = 0;
      end
      box = pack_box(x, y, w, h);
      if (style == 4 && r == 0) box = {$urandom, $urandom};
      set_screen(i, box);
    end
    set_count(($urandom_range(0, 9) < 6) ? BOX_REGS : int'($urandom_range(0, 7)));
    write_reg(REG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 2)), {$urandom, $urandom});
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_request = 1'b0;
      end else if (sink_jitter && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat (idle_length()) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("pointer_screen_seam_crossing: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    pointer_x        = '0;
    pointer_y        = '0;
    delta_x          = '0;
    delta_y          = '0;
    send_jitter      = 1'b0;
    sink_jitter      = 1'b0;
    hold_off_request = 1'b0;
    foreach (screen_plan[i]) screen_plan[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // no screens after reset: never cross
    push_request(100 * PIXEL, 100 * PIXEL, 5000 * PIXEL, 0);
    push_request(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
    settle();

    set_screen(0, pack_box(0, 0, 1920, 1080));
    set_screen(1, pack_box(2020, 200, 1280, 1024));
    set_screen(2, pack_box(0, 1080, 800, 600));
    set_screen(3, pack_box(-1280, -300, 1280, 800));
    set_count(BOX_REGS);
    sink_jitter = 1'b1;
    push_request(1900 * PIXEL, 500 * PIXEL, 150 * PIXEL, 0);
    push_request(1900 * PIXEL, 100 * PIXEL, 150 * PIXEL, 0);
    push_request(1920 * PIXEL - 1, 100 * PIXEL, 1, 0);
    // right exit finds nothing, fall back to the screen below
    push_request(1900 * PIXEL, 1070 * PIXEL, 50 * PIXEL, 100 * PIXEL);
    push_request(10 * PIXEL, 600 * PIXEL, -500 * PIXEL, 0);
    push_request(500 * PIXEL, 10 * PIXEL, 0, -100 * PIXEL);
    push_request(5000 * PIXEL, 5000 * PIXEL, PIXEL, PIXEL);
    push_request(100 * PIXEL, 100 * PIXEL, COORD_MAX, COORD_MAX);
    push_request(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    push_request(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    push_request(0, 0, COORD_MIN, COORD_MAX);
    push_request(-1, -1, 1, 1);
    settle();

    // destination past the coordinate range, disabled slots, count above the slots
    set_screen(0, pack_box(32000, 0, 500, 100));
    set_screen(1, pack_box(32600, 200, 60000, 100));
    set_screen(2, pack_box(32000, 40, 0, 50));
    set_screen(3, pack_box(33000, 50, 300, 0));
    set_count(7);
    push_request(32400 * PIXEL, 50 * PIXEL, COORD_MAX, 0);
    push_request(32400 * PIXEL, 50 * PIXEL, 700 * PIXEL, 0);
    settle();

    // equal distance to two candidates goes to the lower slot; slot three is out of count
    set_screen(0, pack_box(0, 0, 100, 100));
    set_screen(1, pack_box(200, -100, 50, 50));
    set_screen(2, pack_box(200, 150, 50, 50));
    set_screen(3, pack_box(200, 0, 100, 100));
    set_count(3);
    write_reg(REG_FIRST_UNUSED, '1);
    push_request(90 * PIXEL, 49 * PIXEL + PIXEL / 2, 150 * PIXEL, 0);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      plan_layout(ph % 5);
      send_jitter = (ph % 3 != 0) && (ph != 3);
      sink_jitter = (ph % 4 != 0);
      if (ph == 3) hold_off_request = 1'b1;
      repeat (PHASE_REQUESTS) push_random_request();
      settle();
    end

    if (fail_count == 0) begin
      $display("pointer_screen_seam_crossing: match");
    end else begin
      $display("pointer_screen_seam_crossing: mismatch");
    end
    $finish;
  end

endmodule
